FILE: design/rgba_overlay_blend_nv12_defines.svh
// Assertion macros shared by the overlay blend RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef RGBA_OVERLAY_BLEND_NV12_DEFINES_SVH
`define RGBA_OVERLAY_BLEND_NV12_DEFINES_SVH
`ifndef SYNTHESIS
`define ROB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rob assertion failed");
`define ROB_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rob assertion failed");
`else
`define ROB_ASSERT(lbl, clk, rst, prop)
`define ROB_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: design/rob_pkg.sv
// Types, constants and arithmetic helpers for the RGBA overlay blend.
// Depends on nothing; used by every module of the block.
package rob_pkg;

   // Default depth of the queue between front and back end.
   localparam int unsigned QUEUE_DEPTH = 2;

   // BT.601 limited-range coefficients.
   localparam logic signed [17:0] COEF_YR = 18'sd66;
   localparam logic signed [17:0] COEF_YG = 18'sd129;
   localparam logic signed [17:0] COEF_YB = 18'sd25;
   localparam logic signed [17:0] COEF_UR = 18'sd38;
   localparam logic signed [17:0] COEF_UG = 18'sd74;
   localparam logic signed [17:0] COEF_UB = 18'sd112;
   localparam logic signed [17:0] COEF_VR = 18'sd112;
   localparam logic signed [17:0] COEF_VG = 18'sd94;
   localparam logic signed [17:0] COEF_VB = 18'sd18;
   localparam logic signed [17:0] ROUND_BIAS = 18'sd128;
   localparam logic signed [17:0] Y_OFFSET = 18'sd16;
   localparam logic signed [17:0] C_OFFSET = 18'sd128;

   // Blend constants.
   localparam logic [7:0] ALPHA_MAX = 8'd255;
   localparam logic [15:0] BLEND_BIAS = 16'd127;

   // Divide by three as multiply by 683 and shift by 11 (exact below 1024).
   localparam logic [20:0] DIV3_MUL = 21'd683;

   // One input item: a 2x2 quad with its overlay pixels.
   typedef struct packed {
      logic [31:0] overlay_pixel_0;
      logic [31:0] overlay_pixel_1;
      logic [31:0] overlay_pixel_2;
      logic [31:0] overlay_pixel_3;
      logic [3:0]  inside_mask;
      logic        chroma_enable;
      logic [7:0]  luma_in_0;
      logic [7:0]  luma_in_1;
      logic [7:0]  luma_in_2;
      logic [7:0]  luma_in_3;
      logic [7:0]  chroma_u_in;
      logic [7:0]  chroma_v_in;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] luma_out_0;
      logic [7:0] luma_out_1;
      logic [7:0] luma_out_2;
      logic [7:0] luma_out_3;
      logic [7:0] chroma_u_out;
      logic [7:0] chroma_v_out;
   } rsp_type;

   // A classified quad as it waits in the queue. Alphas are already zeroed
   // for pixels outside the mask, so a blend with them leaves the byte as is.
   typedef struct packed {
      logic [3:0][23:0] rgb;
      logic [3:0][7:0]  alpha;
      logic [3:0][7:0]  luma;
      logic [9:0]       sum_r;
      logic [9:0]       sum_g;
      logic [9:0]       sum_b;
      logic [9:0]       sum_a;
      logic [2:0]       count;
      logic             chroma_apply;
      logic [7:0]       u_in;
      logic [7:0]       v_in;
   } work_type;

   // Queue status seen by the front and back end.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Clamp a signed intermediate to one byte.
   function automatic logic [7:0] clamp_byte(input logic signed [17:0] x);
      logic [7:0] res;
      priority if (x < 18'sd0) begin
         res = 8'd0;
      end else if (x > 18'sd255) begin
         res = 8'd255;
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

   // RGB (R in bits 7:0) to packed {V, U, Y} with floor shifts and clamping.
   function automatic logic [23:0] rgb_to_yuv(input logic [23:0] rgb);
      logic signed [17:0] r;
      logic signed [17:0] g;
      logic signed [17:0] b;
      logic signed [17:0] ty;
      logic signed [17:0] tu;
      logic signed [17:0] tv;
      r = $signed({10'b0, rgb[7:0]});
      g = $signed({10'b0, rgb[15:8]});
      b = $signed({10'b0, rgb[23:16]});
      ty = COEF_YR * r + COEF_YG * g + COEF_YB * b + ROUND_BIAS;
      tu = COEF_UB * b - COEF_UR * r - COEF_UG * g + ROUND_BIAS;
      tv = COEF_VR * r - COEF_VG * g - COEF_VB * b + ROUND_BIAS;
      return {clamp_byte((tv >>> 8) + C_OFFSET),
              clamp_byte((tu >>> 8) + C_OFFSET),
              clamp_byte((ty >>> 8) + Y_OFFSET)};
   endfunction

   // Truncating average of a sum over one to four pixels.
   function automatic logic [7:0] avg_div(input logic [9:0] sum, input logic [2:0] count);
      logic [20:0] prod;
      logic [7:0]  res;
      prod = {11'b0, sum} * DIV3_MUL;
      unique case (count)
         3'd1:    res = sum[7:0];
         3'd2:    res = sum[8:1];
         3'd3:    res = prod[18:11];
         3'd4:    res = sum[9:2];
         default: res = 8'd0;
      endcase
      return res;
   endfunction

   // Blend numerator s*a + d*(255-a) + 127, at most 65152.
   function automatic logic [15:0] blend_num(input logic [7:0] s, input logic [7:0] d,
                                             input logic [7:0] a);
      return {8'b0, s} * {8'b0, a} + {8'b0, d} * {8'b0, ALPHA_MAX - a} + BLEND_BIAS;
   endfunction

   // Exact floor(n / 255) for n below 65280.
   function automatic logic [7:0] div255(input logic [15:0] n);
      logic [16:0] t;
      t = {1'b0, n} + {9'b0, n[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

FILE: design/rgba_overlay_blend_nv12.sv
// Path: an accepted quad passes one queue slot and four pipeline stages to rsp_valid.
// Throughput: one quad per cycle; the back end pops any queued quad, so busy never rises.
// Reset is synchronous and active high: it empties the queue and clears pipeline valids.
// Depends on rob_pkg, rob_front, rob_queue, rob_back and the defines header.
`include "rgba_overlay_blend_nv12_defines.svh"
module rgba_overlay_blend_nv12 #(
   parameter int unsigned QueueDepth = rob_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rob_pkg::req_type req_data,
   output logic             rsp_valid,
   output rob_pkg::rsp_type rsp_data
);

   logic                      accept;
   logic                      push;
   logic                      pop;
   rob_pkg::work_type         push_entry;
   rob_pkg::work_type         head;
   rob_pkg::queue_status_type status;

   // A quad transfers when start is high and the queue has room.
   assign busy = status.full;
   assign accept = start && !busy;

   // Front end: classify the quad.
   rob_front u_front (
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .entry    (push_entry)
   );

   // Queue between the two ends.
   rob_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   // Back end: convert and blend.
   rob_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `ROB_ASSERT(a_latency, clock, reset, accept |-> ##5 rsp_valid)
   `ROB_ASSERT(a_no_spurious, clock, reset, !accept |-> ##5 !rsp_valid)
   `ROB_ASSERT_NEVER(a_never_busy, clock, reset, busy)

endmodule

FILE: design/rob_front.sv
// Front end of the overlay blend: unpacks a quad and classifies its pixels.
// Depends on rob_pkg.
module rob_front (
   input  logic             accept,
   input  rob_pkg::req_type req_data,
   output logic             push,
   output rob_pkg::work_type entry
);

   logic [3:0][31:0] pixel;
   logic [3:0][7:0]  luma;
   logic [3:0][7:0]  r_in;
   logic [3:0][7:0]  g_in;
   logic [3:0][7:0]  b_in;
   logic [3:0][7:0]  a_in;

   assign push = accept;

   assign pixel = {req_data.overlay_pixel_3, req_data.overlay_pixel_2,
                   req_data.overlay_pixel_1, req_data.overlay_pixel_0};
   assign luma = {req_data.luma_in_3, req_data.luma_in_2,
                  req_data.luma_in_1, req_data.luma_in_0};

   // Mask each pixel's channels so outside pixels add nothing and blend as no-ops.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         r_in[k] = req_data.inside_mask[k] ? pixel[k][7:0] : 8'd0;
         g_in[k] = req_data.inside_mask[k] ? pixel[k][15:8] : 8'd0;
         b_in[k] = req_data.inside_mask[k] ? pixel[k][23:16] : 8'd0;
         a_in[k] = req_data.inside_mask[k] ? pixel[k][31:24] : 8'd0;
      end
   end

   // Build the queue entry with the channel sums for the chroma average.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         entry.rgb[k] = pixel[k][23:0];
      end
      entry.alpha = a_in;
      entry.luma = luma;
      entry.sum_r = {2'b0, r_in[0]} + {2'b0, r_in[1]} + {2'b0, r_in[2]} + {2'b0, r_in[3]};
      entry.sum_g = {2'b0, g_in[0]} + {2'b0, g_in[1]} + {2'b0, g_in[2]} + {2'b0, g_in[3]};
      entry.sum_b = {2'b0, b_in[0]} + {2'b0, b_in[1]} + {2'b0, b_in[2]} + {2'b0, b_in[3]};
      entry.sum_a = {2'b0, a_in[0]} + {2'b0, a_in[1]} + {2'b0, a_in[2]} + {2'b0, a_in[3]};
      entry.count = {2'b0, req_data.inside_mask[0]} + {2'b0, req_data.inside_mask[1]}
                  + {2'b0, req_data.inside_mask[2]} + {2'b0, req_data.inside_mask[3]};
      entry.chroma_apply = req_data.chroma_enable && (req_data.inside_mask != 4'd0)
                         && (entry.sum_a != 10'd0);
      entry.u_in = req_data.chroma_u_in;
      entry.v_in = req_data.chroma_v_in;
   end

endmodule

FILE: design/rob_queue.sv
// Short queue of classified quads between the front and the back end.
// Depends on rob_pkg and rgba_overlay_blend_nv12_defines.svh.
`include "rgba_overlay_blend_nv12_defines.svh"
module rob_queue #(
   parameter int unsigned Depth = rob_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rob_pkg::work_type         push_entry,
   input  logic                      pop,
   output rob_pkg::work_type         head,
   output rob_pkg::queue_status_type status
);

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   rob_pkg::work_type  mem_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff;
   logic [PtrW-1:0]    wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff;
   logic [PtrW-1:0]    rd_ptr_in;
   logic [CntW-1:0]    count_ff;
   logic [CntW-1:0]    count_in;

   assign head = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full = (count_ff == CntW'(Depth));

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `ROB_ASSERT(a_push_not_full, clock, reset, push |-> !status.full)
   `ROB_ASSERT(a_pop_not_empty, clock, reset, pop |-> !status.empty)
   `ROB_ASSERT(a_count_up, clock, reset, (push && !pop) |=> count_ff == $past(count_ff) + CntW'(1))

endmodule

FILE: design/rob_back.sv
// Back end of the overlay blend: averaging, color conversion and blending.
// Depends on rob_pkg.
module rob_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rob_pkg::queue_status_type status,
   input  rob_pkg::work_type         head,
   output logic                      pop,
   output logic                      rsp_valid,
   output rob_pkg::rsp_type          rsp_data
);

   // Stage 1: averaged chroma source and the blend operands.
   logic             s1_valid_ff;
   logic [4:0][23:0] s1_rgb_ff;
   logic [4:0][23:0] s1_rgb_in;
   logic [4:0][7:0]  s1_alpha_ff;
   logic [4:0][7:0]  s1_alpha_in;
   logic [5:0][7:0]  s1_dst_ff;
   logic [5:0][7:0]  s1_dst_in;

   // Stage 2: converted sources.
   logic             s2_valid_ff;
   logic [5:0][7:0]  s2_src_ff;
   logic [5:0][7:0]  s2_src_in;
   logic [4:0][7:0]  s2_alpha_ff;
   logic [5:0][7:0]  s2_dst_ff;
   logic [3:0][23:0] pix_yuv;
   logic [23:0]      avg_yuv;

   // Stage 3: blend numerators.
   logic             s3_valid_ff;
   logic [5:0][15:0] s3_num_ff;
   logic [5:0][15:0] s3_num_in;

   // Stage 4: result register.
   logic             rsp_valid_ff;
   rob_pkg::rsp_type rsp_ff;
   rob_pkg::rsp_type rsp_in;

   // The back end never stalls, so it takes the queue head whenever there is one.
   assign pop = !status.empty;

   // Stage 1 logic: truncating averages; chroma alpha forced to zero when not applied.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s1_rgb_in[k] = head.rgb[k];
         s1_alpha_in[k] = head.alpha[k];
         s1_dst_in[k] = head.luma[k];
      end
      s1_rgb_in[4] = {rob_pkg::avg_div(head.sum_b, head.count),
                      rob_pkg::avg_div(head.sum_g, head.count),
                      rob_pkg::avg_div(head.sum_r, head.count)};
      s1_alpha_in[4] = head.chroma_apply ? rob_pkg::avg_div(head.sum_a, head.count) : 8'd0;
      s1_dst_in[4] = head.u_in;
      s1_dst_in[5] = head.v_in;
   end

   // Stage 2 logic: BT.601 conversion of the four pixels and of the average.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pix_yuv[k] = rob_pkg::rgb_to_yuv(s1_rgb_ff[k]);
         s2_src_in[k] = pix_yuv[k][7:0];
      end
      avg_yuv = rob_pkg::rgb_to_yuv(s1_rgb_ff[4]);
      s2_src_in[4] = avg_yuv[15:8];
      s2_src_in[5] = avg_yuv[23:16];
   end

   // Stage 3 logic: blend numerators; both chroma lanes share the average alpha.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         s3_num_in[k] = rob_pkg::blend_num(s2_src_ff[k], s2_dst_ff[k],
                                           s2_alpha_ff[(k < 4) ? k : 4]);
      end
   end

   // Stage 4 logic: divide by 255.
   always_comb begin
      rsp_in.luma_out_0 = rob_pkg::div255(s3_num_ff[0]);
      rsp_in.luma_out_1 = rob_pkg::div255(s3_num_ff[1]);
      rsp_in.luma_out_2 = rob_pkg::div255(s3_num_ff[2]);
      rsp_in.luma_out_3 = rob_pkg::div255(s3_num_ff[3]);
      rsp_in.chroma_u_out = rob_pkg::div255(s3_num_ff[4]);
      rsp_in.chroma_v_out = rob_pkg::div255(s3_num_ff[5]);
   end

   // Valid flags of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers of the pipeline.
   always_ff @(posedge clock) begin
      s1_rgb_ff <= s1_rgb_in;
      s1_alpha_ff <= s1_alpha_in;
      s1_dst_ff <= s1_dst_in;
      s2_src_ff <= s2_src_in;
      s2_alpha_ff <= s1_alpha_ff;
      s2_dst_ff <= s1_dst_ff;
      s3_num_ff <= s3_num_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: verif/rgba_overlay_blend_nv12_tb.sv
// Self-checking testbench for the RGBA overlay blend onto one NV12 quad.
// Predicts every quad's blended luma and chroma and checks each strobed result.
// Depends on rob_pkg and the rgba_overlay_blend_nv12 top level.
`timescale 1ns / 1ps

module rgba_overlay_blend_nv12_tb;

   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned RANDOM_QUADS = 1750;
   localparam int unsigned DRAIN_EVERY = 400;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   rob_pkg::req_type req_data = '0;
   logic             rsp_valid;
   rob_pkg::rsp_type rsp_data;

   // Quads waiting to be driven, with a flag that holds the sender off until
   // every blended result so far has come back.
   rob_pkg::req_type quad_q [$];
   bit               drain_q [$];
   // Blended results predicted for accepted quads, oldest first.
   rob_pkg::rsp_type blended_q [$];

   int unsigned quads_total = 0;
   int unsigned quads_accepted = 0;
   int unsigned errors = 0;
   int unsigned gap_left = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;

   string field_names [6] = '{"luma_out_0", "luma_out_1", "luma_out_2", "luma_out_3",
                              "chroma_u_out", "chroma_v_out"};

   rgba_overlay_blend_nv12 DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Prints one mismatch line and counts it.
   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic int clamp8(input int x);
      if (x < 0) return 0;
      if (x > 255) return 255;
      return x;
   endfunction

   // BT.601 limited range; >>> on a signed int is a floor shift.
   function automatic void to_yuv(input int r, input int g, input int b,
                                  output int y, output int u, output int v);
      y = clamp8(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
      u = clamp8(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
      v = clamp8(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
   endfunction

   function automatic int mix8(input int s, input int d, input int a);
      int q;
      q = (s * a + d * (255 - a) + 127) / 255;
      return (q > 255) ? 255 : q;
   endfunction

   // Expected result of one quad.
   function automatic rob_pkg::rsp_type blend_quad(input rob_pkg::req_type q);
      rob_pkg::rsp_type res;
      logic [31:0]      px [4];
      logic [7:0]       luma [4];
      int               r, g, b, a, y, u, v;
      int               r_sum, g_sum, b_sum, a_sum, inside_cnt;
      px[0] = q.overlay_pixel_0;
      px[1] = q.overlay_pixel_1;
      px[2] = q.overlay_pixel_2;
      px[3] = q.overlay_pixel_3;
      luma[0] = q.luma_in_0;
      luma[1] = q.luma_in_1;
      luma[2] = q.luma_in_2;
      luma[3] = q.luma_in_3;
      r_sum = 0;
      g_sum = 0;
      b_sum = 0;
      a_sum = 0;
      inside_cnt = 0;
      for (int k = 0; k < 4; k++) begin
         r = px[k][7:0];
         g = px[k][15:8];
         b = px[k][23:16];
         a = px[k][31:24];
         if (q.inside_mask[k]) begin
            if (a != 0) begin
               to_yuv(r, g, b, y, u, v);
               luma[k] = 8'(mix8(y, luma[k], a));
            end
            r_sum += r;
            g_sum += g;
            b_sum += b;
            a_sum += a;
            inside_cnt++;
         end
      end
      res.luma_out_0 = luma[0];
      res.luma_out_1 = luma[1];
      res.luma_out_2 = luma[2];
      res.luma_out_3 = luma[3];
      res.chroma_u_out = q.chroma_u_in;
      res.chroma_v_out = q.chroma_v_in;
      // Chroma uses the truncated averages of the inside pixels.
      if (q.chroma_enable && inside_cnt != 0 && a_sum != 0) begin
         to_yuv(r_sum / inside_cnt, g_sum / inside_cnt, b_sum / inside_cnt, y, u, v);
         res.chroma_u_out = 8'(mix8(u, q.chroma_u_in, a_sum / inside_cnt));
         res.chroma_v_out = 8'(mix8(v, q.chroma_v_in, a_sum / inside_cnt));
      end
      return res;
   endfunction

   function automatic logic [31:0] rgba(input int r, input int g, input int b, input int a);
      return {8'(a), 8'(b), 8'(g), 8'(r)};
   endfunction

   function automatic int rand_byte();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll == 0) return 0;
      if (roll == 1) return 255;
      return $urandom_range(255);
   endfunction

   // Alpha leans toward zero, opaque and tiny values to hit the corner blends.
   function automatic logic [31:0] rand_pixel();
      int unsigned roll;
      int          a;
      roll = $urandom_range(99);
      if (roll < 20) a = 0;
      else if (roll < 40) a = 255;
      else if (roll < 50) a = $urandom_range(3, 1);
      else a = $urandom_range(255);
      if ($urandom_range(9) == 0) return $urandom();
      return rgba(rand_byte(), rand_byte(), rand_byte(), a);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic add_quad(input logic [31:0] p0, input logic [31:0] p1,
                           input logic [31:0] p2, input logic [31:0] p3,
                           input int mask, input bit chroma_en,
                           input int l0, input int l1, input int l2, input int l3,
                           input int u, input int v, input bit drain_first);
      rob_pkg::req_type q;
      q.overlay_pixel_0 = p0;
      q.overlay_pixel_1 = p1;
      q.overlay_pixel_2 = p2;
      q.overlay_pixel_3 = p3;
      q.inside_mask = 4'(mask);
      q.chroma_enable = chroma_en;
      q.luma_in_0 = 8'(l0);
      q.luma_in_1 = 8'(l1);
      q.luma_in_2 = 8'(l2);
      q.luma_in_3 = 8'(l3);
      q.chroma_u_in = 8'(u);
      q.chroma_v_in = 8'(v);
      quad_q.push_back(q);
      drain_q.push_back(drain_first);
   endtask

   // Driver: records each transfer, then holds, idles or presents the next quad.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            blended_q.push_back(blend_quad(req_data));
            quads_accepted++;
         end
         if (!start || !busy) begin
            if (gap_left != 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (quad_q.size() != 0 && !(drain_q[0] && blended_q.size() != 0)) begin
               req_data <= quad_q.pop_front();
               void'(drain_q.pop_front());
               start <= 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  gap_left = pick_gap();
                  if ($urandom_range(49) == 0) burst_left = $urandom_range(80, 20);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (blended_q.size() == 0) begin
            report($sformatf("result %h with no quad outstanding", rsp_data));
         end else begin
            logic [47:0] got;
            logic [47:0] want;
            got = rsp_data;
            want = blended_q.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (got[47 - 8 * i -: 8] !== want[47 - 8 * i -: 8]) begin
                  report($sformatf("%s got %0d expected %0d", field_names[i],
                                   got[47 - 8 * i -: 8], want[47 - 8 * i -: 8]));
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      // Directed: empty mask, opaque extremes and fully transparent pixels.
      add_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_quad('1, '1, '1, '1, 4'hF, 1, 0, 0, 0, 0, 0, 0, 0);
      add_quad(rgba(0, 0, 0, 255), rgba(0, 0, 0, 255), rgba(0, 0, 0, 255),
               rgba(0, 0, 0, 255), 4'hF, 1, 255, 255, 255, 255, 255, 255, 0);
      add_quad(rgba(255, 10, 200, 0), rgba(1, 2, 3, 0), rgba(90, 90, 90, 0),
               rgba(255, 255, 255, 0), 4'hF, 1, 12, 34, 56, 78, 90, 160, 0);
      // Primaries push the chroma terms negative, exercising the floor shift.
      add_quad(rgba(255, 0, 0, 255), rgba(0, 255, 0, 255), rgba(0, 0, 255, 255),
               rgba(255, 255, 0, 128), 4'hF, 1, 100, 150, 200, 250, 30, 220, 0);
      // Chroma disabled leaves U and V as they are.
      add_quad('1, '1, '1, '1, 4'hF, 0, 1, 2, 3, 4, 5, 6, 0);
      // One inside pixel at each position.
      add_quad(rgba(255, 0, 0, 255), rgba(0, 255, 0, 255), rgba(0, 0, 255, 255),
               rgba(9, 9, 9, 255), 4'h1, 1, 50, 60, 70, 80, 40, 200, 0);
      add_quad(rgba(255, 0, 0, 255), rgba(0, 255, 0, 255), rgba(0, 0, 255, 255),
               rgba(9, 9, 9, 255), 4'h2, 1, 50, 60, 70, 80, 40, 200, 0);
      add_quad(rgba(255, 0, 0, 255), rgba(0, 255, 0, 255), rgba(0, 0, 255, 255),
               rgba(9, 9, 9, 255), 4'h4, 1, 50, 60, 70, 80, 40, 200, 0);
      add_quad(rgba(255, 0, 0, 255), rgba(0, 255, 0, 255), rgba(0, 0, 255, 255),
               rgba(9, 9, 9, 255), 4'h8, 1, 50, 60, 70, 80, 40, 200, 0);
      // Three inside pixels need a true divide by three.
      add_quad(rgba(255, 254, 253, 255), rgba(255, 255, 255, 254), rgba(254, 255, 1, 253),
               rgba(0, 0, 0, 255), 4'h7, 1, 0, 128, 255, 7, 0, 255, 0);
      add_quad(rgba(3, 4, 5, 6), rgba(100, 0, 255, 77), rgba(17, 200, 33, 1),
               rgba(250, 128, 64, 200), 4'hE, 1, 255, 0, 255, 0, 128, 128, 0);
      // Two inside pixels.
      add_quad(rgba(200, 100, 50, 255), rgba(1, 1, 1, 1), rgba(10, 20, 30, 40),
               rgba(255, 0, 255, 254), 4'h9, 1, 90, 91, 92, 93, 94, 95, 0);
      // Nonzero alpha sum whose average truncates to zero.
      add_quad(rgba(255, 0, 0, 1), rgba(0, 255, 0, 1), rgba(0, 0, 255, 1),
               rgba(255, 255, 255, 0), 4'hF, 1, 10, 20, 30, 40, 50, 60, 0);
      // Inside alphas sum to zero while the outside pixels are opaque.
      add_quad(rgba(255, 0, 0, 0), rgba(0, 255, 0, 255), rgba(0, 0, 255, 0),
               rgba(255, 255, 255, 255), 4'h5, 1, 11, 22, 33, 44, 55, 66, 0);
      // Empty mask with chroma enabled and opaque pixels.
      add_quad('1, '1, '1, '1, 0, 1, 200, 201, 202, 203, 204, 205, 0);
      // Half and near-opaque alpha against the byte extremes.
      add_quad(rgba(255, 255, 255, 128), rgba(0, 0, 0, 127), rgba(255, 255, 255, 1),
               rgba(0, 0, 0, 254), 4'hF, 1, 0, 255, 0, 255, 0, 255, 0);
      add_quad(rgba(128, 128, 128, 255), rgba(0, 255, 255, 255), rgba(255, 0, 255, 255),
               rgba(255, 255, 0, 255), 4'hF, 1, 255, 0, 255, 0, 255, 0, 0);

      // Random quads; the sender drains completely at the start and at a few later points.
      for (int n = 0; n < RANDOM_QUADS; n++) begin
         int mask;
         mask = ($urandom_range(9) < 4) ? 4'hF : $urandom_range(15);
         add_quad(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(), mask,
                  $urandom_range(3) != 0, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), (n % DRAIN_EVERY) == 0);
      end
      quads_total = quad_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (quads_accepted != quads_total) @(posedge clock);
      while (blended_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
